@@ rtl/core/counting_semaphore_wait_queue_macros.svh @@
// assertion macros shared by the semaphore checker
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_MACROS_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_MACROS_SVH

// implication checked at every edge outside reset
`define CSQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csq check failed");

// implication checked in the following cycle
`define CSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csq check failed");

`endif

@@ rtl/core/csq_pkg.sv @@
// package: constants, opcodes and cell link types of the semaphore
`default_nettype none

package csq_pkg;

    localparam int QueueDepth = 16;
    localparam int IdBits     = 8;
    localparam int CountW     = 16;
    localparam int ThreadW    = 8;
    localparam int OpcodeW    = 2;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    typedef enum logic [OpcodeW-1:0] {
        OP_DOWN   = 2'd0,
        OP_UP     = 2'd1,
        OP_REINIT = 2'd2
    } op_t;

    // broadcast to every cell
    typedef struct packed {
        logic down;
        logic append;
        logic clear;
    } cell_ctl_t;

    // passed from a cell to the next higher slot
    typedef struct packed {
        logic hit;
        logic post_valid;
    } chain_fwd_t;

endpackage

`default_nettype wire

@@ rtl/core/csq_if.sv @@
// request and response channel interfaces
`default_nettype none

interface csq_req_if;
    logic                            valid;
    logic                            ready;
    logic [csq_pkg::OpcodeW-1:0]     opcode;
    logic [csq_pkg::ThreadW-1:0]     thread_id;

    modport source (output valid, output opcode, output thread_id, input ready);
    modport sink (input valid, input opcode, input thread_id, output ready);
endinterface

interface csq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            granted;
    logic                            wake_valid;
    logic [csq_pkg::ThreadW-1:0]     wake_thread;
    logic                            queue_overflow;
    logic                            count_saturated;
    logic [csq_pkg::CountW-1:0]      count_now;

    modport source (
        output valid, output granted, output wake_valid, output wake_thread,
        output queue_overflow, output count_saturated, output count_now,
        input ready
    );
    modport sink (
        input valid, input granted, input wake_valid, input wake_thread,
        input queue_overflow, input count_saturated, input count_now,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/csq_cell.sv @@
// one wait queue slot: id, valid bit, match, shift and fill logic
`default_nettype none

module csq_cell #(
    parameter int ID_BITS = csq_pkg::IdBits
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire csq_pkg::cell_ctl_t ctl,
    input  wire logic [ID_BITS-1:0] op_id,
    input  wire csq_pkg::chain_fwd_t fwd_in,
    output csq_pkg::chain_fwd_t     fwd_out,
    input  wire logic [ID_BITS-1:0] nxt_id,
    input  wire logic               nxt_valid,
    output logic [ID_BITS-1:0]      cur_id,
    output logic                    cur_valid
);

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic               valid_reg;
    logic               valid_next;
    logic               match;
    logic               shift;
    logic [ID_BITS-1:0] post_id;
    logic               post_valid;
    logic               fill;

    always_comb
    begin
        match      = valid_reg && (id_reg == op_id);
        // close the gap left by the first matching slot at or below this one
        shift      = ctl.down && (fwd_in.hit || match);
        post_id    = shift ? nxt_id : id_reg;
        post_valid = shift ? nxt_valid : valid_reg;
        // first free slot of the packed queue
        fill       = ctl.append && !post_valid && fwd_in.post_valid;

        fwd_out.hit        = fwd_in.hit || match;
        fwd_out.post_valid = post_valid;

        priority if (ctl.clear)
        begin
            id_next    = id_reg;
            valid_next = 1'b0;
        end
        else if (fill)
        begin
            id_next    = op_id;
            valid_next = 1'b1;
        end
        else
        begin
            id_next    = post_id;
            valid_next = post_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign cur_id    = id_reg;
    assign cur_valid = valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/counting_semaphore_wait_queue.sv @@
// top level: counting semaphore with an ordered wait queue of thread ids
// Takes one item per clock on req and returns one response item on rsp for each,
// in the cycle after acceptance; req.ready stays high while the response register is
// empty or being taken, so with rsp.ready held high the block sustains one item
// every cycle. The cycle time is set by the ripple of the match and free-slot
// signals through the QUEUE_DEPTH slot cells. Opcodes: down attempt, up,
// reinitialize (loads the count from the cfg register and empties the queue);
// opcode 3 changes nothing and reports the current count. The queue is kept
// packed toward slot 0; valid bits sit in flops, so reset empties it at once and
// no clearing pass is needed. Only the low ID_BITS bits of thread_id are kept.
`default_nettype none

module counting_semaphore_wait_queue #(
    parameter int QUEUE_DEPTH = csq_pkg::QueueDepth,
    parameter int ID_BITS     = csq_pkg::IdBits
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    csq_req_if.sink                          req,
    csq_rsp_if.source                        rsp,
    input  wire logic                        cfg_wr_en,
    input  wire logic [csq_pkg::CountW-1:0]  cfg_wr_data
);

    // configuration and count
    logic [csq_pkg::CountW-1:0]  init_reg;
    logic [csq_pkg::CountW-1:0]  count_reg;
    logic [csq_pkg::CountW-1:0]  count_next;

    // response register
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic                        granted_reg;
    logic                        wake_valid_reg;
    logic [csq_pkg::ThreadW-1:0] wake_thread_reg;
    logic                        overflow_reg;
    logic                        saturated_reg;
    logic [csq_pkg::CountW-1:0]  count_now_reg;

    // per-item decode
    logic                        accept;
    csq_pkg::op_t                op;
    logic [ID_BITS-1:0]          op_id;
    logic                        count_zero;
    csq_pkg::cell_ctl_t          ctl;
    logic                        granted_c;
    logic                        wake_valid_c;
    logic [csq_pkg::ThreadW-1:0] wake_thread_c;
    logic                        overflow_c;
    logic                        saturated_c;

    // cell chain links: fwd runs toward the tail, id/valid toward the head
    csq_pkg::chain_fwd_t         fwd   [QUEUE_DEPTH+1];
    logic [ID_BITS-1:0]          ids   [QUEUE_DEPTH+1];
    logic                        valids[QUEUE_DEPTH+1];

    // a new item may enter while the response register is empty or its response is taken
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign op        = csq_pkg::op_t'(req.opcode);
    assign op_id     = ID_BITS'(req.thread_id);
    assign count_zero = (count_reg == '0);

    // head of chain sees no earlier match and an occupied left neighbor
    assign fwd[0].hit        = 1'b0;
    assign fwd[0].post_valid = 1'b1;
    // beyond the tail the queue is empty
    assign ids[QUEUE_DEPTH]    = '0;
    assign valids[QUEUE_DEPTH] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            csq_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .op_id     (op_id),
                .fwd_in    (fwd[gi]),
                .fwd_out   (fwd[gi+1]),
                .nxt_id    (ids[gi+1]),
                .nxt_valid (valids[gi+1]),
                .cur_id    (ids[gi]),
                .cur_valid (valids[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ctl            = '0;
        count_next     = count_reg;
        granted_c      = 1'b0;
        wake_valid_c   = 1'b0;
        wake_thread_c  = '0;
        overflow_c     = 1'b0;
        saturated_c    = 1'b0;

        if (accept)
        begin
            unique case (op)
                csq_pkg::OP_DOWN:
                begin
                    // removal of the caller always happens; then grant or queue
                    ctl.down = 1'b1;
                    if (!count_zero)
                    begin
                        count_next = count_reg - 1'b1;
                        granted_c  = 1'b1;
                    end
                    else
                    begin
                        ctl.append = 1'b1;
                        // tail still occupied after removal: queue is full
                        overflow_c = fwd[QUEUE_DEPTH].post_valid;
                    end
                end
                csq_pkg::OP_UP:
                begin
                    // head is reported, not dequeued
                    wake_valid_c  = valids[0];
                    wake_thread_c = valids[0] ? csq_pkg::ThreadW'(ids[0]) : '0;
                    if (count_reg == csq_pkg::CountMax)
                    begin
                        saturated_c = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                csq_pkg::OP_REINIT:
                begin
                    ctl.clear  = 1'b1;
                    count_next = init_reg;
                end
                default:
                begin
                    // unused opcode: no change
                    count_next = count_reg;
                end
            endcase
        end

        rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                init_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            granted_reg     <= granted_c;
            wake_valid_reg  <= wake_valid_c;
            wake_thread_reg <= wake_thread_c;
            overflow_reg    <= overflow_c;
            saturated_reg   <= saturated_c;
            count_now_reg   <= count_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.granted         = granted_reg;
    assign rsp.wake_valid      = wake_valid_reg;
    assign rsp.wake_thread     = wake_thread_reg;
    assign rsp.queue_overflow  = overflow_reg;
    assign rsp.count_saturated = saturated_reg;
    assign rsp.count_now       = count_now_reg;

endmodule

`default_nettype wire

@@ rtl/core/csq_checker.sv @@
// port level checks for the semaphore and their bind to the top level
`default_nettype none
`include "counting_semaphore_wait_queue_macros.svh"

module csq_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic                        granted,
    input wire logic                        wake_valid,
    input wire logic [csq_pkg::ThreadW-1:0] wake_thread,
    input wire logic                        queue_overflow,
    input wire logic                        count_saturated
);

    `CSQ_ASSERT_NEXT(a_accept_gives_rsp, clk, rst_n, req_valid && req_ready, rsp_valid)
    `CSQ_ASSERT_IMPLY(a_stalled_rsp_blocks_req, clk, rst_n, rsp_valid && !rsp_ready, !req_ready)
    `CSQ_ASSERT_IMPLY(a_down_flags_exclusive, clk, rst_n, rsp_valid && (granted || queue_overflow), !(granted && queue_overflow) && !wake_valid && !count_saturated)
    `CSQ_ASSERT_IMPLY(a_wake_thread_idle_zero, clk, rst_n, rsp_valid && !wake_valid, wake_thread == '0)

endmodule

bind counting_semaphore_wait_queue csq_checker u_csq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .granted         (rsp.granted),
    .wake_valid      (rsp.wake_valid),
    .wake_thread     (rsp.wake_thread),
    .queue_overflow  (rsp.queue_overflow),
    .count_saturated (rsp.count_saturated)
);

`default_nettype wire

@@ tb/sv/tb_counting_semaphore_wait_queue.sv @@
// testbench: semaphore wait-queue block checked against a cycle-free predictor
`default_nettype none

module tb_counting_semaphore_wait_queue;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode 3 has no meaning, the block must report the count and change nothing
    localparam logic [csq_pkg::OpcodeW-1:0] OP_UNUSED = 2'd3;
    localparam logic [csq_pkg::ThreadW-1:0] ID_MASK =
        csq_pkg::ThreadW'((1 << csq_pkg::IdBits) - 1);
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int POOL_SIZE      = 24;

    typedef enum {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

    // one response item as the predictor sees it
    typedef struct packed {
        logic                         granted;
        logic                         wake_valid;
        logic [csq_pkg::ThreadW-1:0]  wake_thread;
        logic                         queue_overflow;
        logic                         count_saturated;
        logic [csq_pkg::CountW-1:0]   count_now;
    } sem_result_t;

    logic clk;
    logic rst_n;
    logic                       cfg_wr_en;
    logic [csq_pkg::CountW-1:0] cfg_wr_data;

    csq_req_if req ();
    csq_rsp_if rsp ();

    counting_semaphore_wait_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state: count, packed wait queue and the reinit register
    logic [csq_pkg::CountW-1:0]  sem_count = '0;
    logic [csq_pkg::CountW-1:0]  reinit_count = '0;
    logic [csq_pkg::ThreadW-1:0] waiter_id [csq_pkg::QueueDepth] = '{default: '0};
    logic                        waiter_on [csq_pkg::QueueDepth] = '{default: 1'b0};

    // expected response items, oldest first
    sem_result_t pending_results [$];

    int fail_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int settings_written = 0;
    int n_grants = 0;
    int n_wakes = 0;
    int n_overflows = 0;
    int n_saturated = 0;

    // sender pacing and receiver behavior, steered by the test tasks
    bit       tx_gaps = 1'b0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    bit       rx_hold_request = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // apply one operation to the predictor state and return the response it implies
    function automatic sem_result_t sem_apply(input logic [csq_pkg::OpcodeW-1:0] op,
                                              input logic [csq_pkg::ThreadW-1:0] raw_id);
        sem_result_t                 r;
        logic [csq_pkg::ThreadW-1:0] tid;
        int                          slot;
        r = '0;
        tid = raw_id & ID_MASK;
        case (op)
            csq_pkg::OP_DOWN:
            begin
                // drop the caller from the queue first, only its first slot
                slot = -1;
                for (int i = 0; i < csq_pkg::QueueDepth; i++)
                    if (slot < 0 && waiter_on[i] && waiter_id[i] == tid)
                        slot = i;
                if (slot >= 0)
                begin
                    for (int j = slot; j < csq_pkg::QueueDepth - 1; j++)
                    begin
                        waiter_id[j] = waiter_id[j + 1];
                        waiter_on[j] = waiter_on[j + 1];
                    end
                    waiter_id[csq_pkg::QueueDepth - 1] = '0;
                    waiter_on[csq_pkg::QueueDepth - 1] = 1'b0;
                end
                if (sem_count != 0)
                begin
                    sem_count--;
                    r.granted = 1'b1;
                    n_grants++;
                end
                else
                begin
                    // no count left: wait at the first free slot, or overflow
                    slot = -1;
                    for (int i = 0; i < csq_pkg::QueueDepth; i++)
                        if (slot < 0 && !waiter_on[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        waiter_id[slot] = tid;
                        waiter_on[slot] = 1'b1;
                    end
                    else
                    begin
                        r.queue_overflow = 1'b1;
                        n_overflows++;
                    end
                end
            end
            csq_pkg::OP_UP:
            begin
                // head is reported, not removed
                if (waiter_on[0])
                begin
                    r.wake_valid = 1'b1;
                    r.wake_thread = waiter_id[0];
                    n_wakes++;
                end
                if (sem_count == csq_pkg::CountMax)
                begin
                    r.count_saturated = 1'b1;
                    n_saturated++;
                end
                else
                    sem_count++;
            end
            csq_pkg::OP_REINIT:
            begin
                sem_count = reinit_count;
                waiter_id = '{default: '0};
                waiter_on = '{default: 1'b0};
            end
            default: ;
        endcase
        r.count_now = sem_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // response checker: every accepted item is matched against the oldest expectation
    always @(posedge clk)
    begin : check_rsp
        sem_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response item with no expected item waiting");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("granted", 32'(want.granted), 32'(rsp.granted));
                check_field("wake_valid", 32'(want.wake_valid), 32'(rsp.wake_valid));
                check_field("wake_thread", 32'(want.wake_thread), 32'(rsp.wake_thread));
                check_field("queue_overflow", 32'(want.queue_overflow),
                            32'(rsp.queue_overflow));
                check_field("count_saturated", 32'(want.count_saturated),
                            32'(rsp.count_saturated));
                check_field("count_now", 32'(want.count_now), 32'(rsp.count_now));
                results_checked++;
            end
        end
    end

    // receiver: open, random or bursty ready, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int run_left;
        bit run_open;
        hold_left = 0;
        run_left = 0;
        run_open = 1'b1;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (!rst_n)
                rsp.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                case (rx_mode)
                    RX_OPEN: rsp.ready <= 1'b1;
                    RX_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        // alternating runs of ready and stall with random lengths
                        if (run_left == 0)
                        begin
                            run_open = !run_open;
                            run_left = run_open ? $urandom_range(1, 12) : $urandom_range(1, 6);
                        end
                        run_left--;
                        rsp.ready <= run_open;
                    end
                endcase
        end
    end

    // offer one item and wait for its handshake; called at a rising edge
    task automatic send_item(input logic [csq_pkg::OpcodeW-1:0] op,
                             input logic [csq_pkg::ThreadW-1:0] id);
        req.valid <= 1'b1;
        req.opcode <= op;
        req.thread_id <= id;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.push_back(sem_apply(op, id));
        items_sent++;
    endtask

    // bursts of random length separated by random gaps, when tx_gaps is set
    task automatic pace_sender();
        if (tx_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 24);
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
        end
    endtask

    // stop offering and wait until every expected item has come back
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // the register is only written with the block idle
    task automatic write_initial_count(input logic [csq_pkg::CountW-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reinit_count = value;
        settings_written++;
    endtask

    // unused opcode straight out of reset: count 0, no flags
    task automatic test_unused_opcode();
        rx_mode = RX_RANDOM;
        send_item(OP_UNUSED, 8'hFF);
    endtask

    // fill the wait queue to overflow, wake the head, remove from the middle and the head
    task automatic test_queue_overflow();
        write_initial_count(16'd0);
        send_item(csq_pkg::OP_REINIT, 8'h00);
        send_item(csq_pkg::OP_DOWN, 8'hFF);
        send_item(csq_pkg::OP_DOWN, 8'h00);
        for (int i = 1; i <= csq_pkg::QueueDepth - 2; i++)
            send_item(csq_pkg::OP_DOWN, csq_pkg::ThreadW'(i * 17));
        // queue is full now, this waiter is dropped
        send_item(csq_pkg::OP_DOWN, 8'hA5);
        // head reported but stays queued
        send_item(csq_pkg::OP_UP, 8'h00);
        // slot 1 leaves, gap closes, count taken
        send_item(csq_pkg::OP_DOWN, 8'h00);
        // head leaves and goes back to the tail since the count is 0 again
        send_item(csq_pkg::OP_DOWN, 8'hFF);
    endtask

    // count climbs to its maximum and then sticks there
    task automatic test_count_saturation();
        write_initial_count(csq_pkg::CountW'(csq_pkg::CountMax - 1));
        send_item(csq_pkg::OP_REINIT, 8'h3C);
        send_item(csq_pkg::OP_UP, 8'h00);
        send_item(csq_pkg::OP_UP, 8'h00);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_back_pressure();
        write_initial_count(16'd5);
        rx_mode = RX_OPEN;
        tx_gaps = 1'b0;
        send_item(csq_pkg::OP_REINIT, 8'h00);
        rx_hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(($urandom_range(0, 1) != 0) ? csq_pkg::OP_DOWN : csq_pkg::OP_UP,
                      csq_pkg::ThreadW'($urandom_range(0, 31)));
        // sender waits for every outstanding item before moving on
        wait_drained();
    endtask

    // random phase: small id pool so threads queue, leave and requeue often
    task automatic run_random_phase(input logic [csq_pkg::CountW-1:0] init,
                                    input int n_items,
                                    input int down_pct, input int up_pct,
                                    input bit gaps, input rx_mode_t mode);
        logic [csq_pkg::ThreadW-1:0] pool [POOL_SIZE];
        logic [csq_pkg::OpcodeW-1:0] op;
        logic [csq_pkg::ThreadW-1:0] id;
        int                          pick;
        write_initial_count(init);
        rx_mode = mode;
        tx_gaps = gaps;
        burst_left = 0;
        foreach (pool[i])
            pool[i] = csq_pkg::ThreadW'($urandom_range(0, 255));
        send_item(csq_pkg::OP_REINIT, csq_pkg::ThreadW'($urandom_range(0, 255)));
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < down_pct)
                op = csq_pkg::OP_DOWN;
            else if (pick < down_pct + up_pct)
                op = csq_pkg::OP_UP;
            else if (pick < down_pct + up_pct + 4)
                op = csq_pkg::OP_REINIT;
            else
                op = OP_UNUSED;
            // mostly known threads, sometimes any id at all
            if ($urandom_range(0, 4) != 0)
                id = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                id = csq_pkg::ThreadW'($urandom_range(0, 255));
            send_item(op, id);
            pace_sender();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'd0, 125, 50, 40, 1'b1, RX_RANDOM);
        run_random_phase(16'd3, 125, 62, 30, 1'b1, RX_BURSTY);
        run_random_phase(csq_pkg::CountMax, 125, 20, 72, 1'b0, RX_OPEN);
        run_random_phase(csq_pkg::CountW'(csq_pkg::CountMax - 1), 120, 40, 52, 1'b1,
                         RX_BURSTY);
        run_random_phase(csq_pkg::CountW'($urandom_range(1, 8)), 125, 50, 42, 1'b0,
                         RX_RANDOM);
        run_random_phase(csq_pkg::CountW'($urandom), 125, 46, 46, 1'b1, RX_OPEN);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        req.valid <= 1'b0;
        req.opcode <= csq_pkg::OP_DOWN;
        req.thread_id <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unused_opcode();
        test_queue_overflow();
        test_count_saturation();
        test_back_pressure();
        test_random_traffic();

        // let the last item through, then print the summary and the verdict
        wait_drained();
        repeat (4)
            @(posedge clk);
        $display("run covered %0d items and %0d checked responses over %0d register settings",
                 items_sent, results_checked, settings_written);
        $display("seen: %0d grants, %0d wakes, %0d queue overflows, %0d saturated ups",
                 n_grants, n_wakes, n_overflows, n_saturated);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
